/* design/rwc_pkg.sv */
// rwc_pkg: shared constants and types for the replay window check.
// Used by rwc_judge, replay_window_check and rwc_checker; depends on nothing.

package rwc_pkg;

    localparam int SEQ_W     = 64;
    localparam int VERDICT_W = 2;

    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_STALE     = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 2'd2;

    // request handed from the input register to the window logic
    typedef struct packed {
        logic             update;
        logic [SEQ_W-1:0] seq;
    } judge_req_t;

endpackage

/* design/rwc_judge.sv */
// rwc_judge: window state (started, highest, bitmap) and the per-request verdict.
// Depends on rwc_pkg.

module rwc_judge #(
    parameter int WINDOW_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rwc_pkg::judge_req_t            req,
    output logic [rwc_pkg::VERDICT_W-1:0]  verdict
);

    localparam int SHW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
    localparam logic [rwc_pkg::SEQ_W-1:0] WIN = rwc_pkg::SEQ_W'(WINDOW_BITS);

    logic                        started_reg;
    logic                        started_next;
    logic [rwc_pkg::SEQ_W-1:0]   highest_reg;
    logic [rwc_pkg::SEQ_W-1:0]   highest_next;
    logic [WINDOW_BITS-1:0]      bitmap_reg;
    logic [WINDOW_BITS-1:0]      bitmap_next;

    logic [rwc_pkg::SEQ_W-1:0]   hi_gap;
    logic [rwc_pkg::SEQ_W-1:0]   lo_gap;
    logic                        is_above;
    logic                        above_far;
    logic                        below_far;
    logic [WINDOW_BITS-1:0]      shifted;
    logic [WINDOW_BITS-1:0]      bit_mask;
    logic                        hit;

    assign hi_gap    = req.seq - highest_reg;
    assign lo_gap    = highest_reg - req.seq;
    assign is_above  = req.seq > highest_reg;
    assign above_far = hi_gap >= WIN;
    assign below_far = lo_gap >= WIN;
    // gap is below the window width whenever these are used, so SHW bits suffice
    assign shifted   = (bitmap_reg << hi_gap[SHW-1:0]) | WINDOW_BITS'(1);
    assign bit_mask  = WINDOW_BITS'(1) << lo_gap[SHW-1:0];
    assign hit       = |(bitmap_reg & bit_mask);

    always_comb
    begin
        started_next = started_reg;
        highest_next = highest_reg;
        bitmap_next  = bitmap_reg;
        verdict      = rwc_pkg::VERDICT_ACCEPTED;
        if (!started_reg)
        begin
            started_next = 1'b1;
            highest_next = req.seq;
            bitmap_next  = WINDOW_BITS'(1);
        end
        else if (is_above)
        begin
            highest_next = req.seq;
            bitmap_next  = above_far ? WINDOW_BITS'(1) : shifted;
        end
        else if (below_far)
        begin
            verdict = rwc_pkg::VERDICT_STALE;
        end
        else if (hit)
        begin
            verdict = rwc_pkg::VERDICT_DUPLICATE;
        end
        else
        begin
            bitmap_next = bitmap_reg | bit_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            highest_reg <= '0;
            bitmap_reg  <= '0;
        end
        else if (req.update)
        begin
            started_reg <= started_next;
            highest_reg <= highest_next;
            bitmap_reg  <= bitmap_next;
        end
    end

endmodule

/* design/replay_window_check.sv */
// replay_window_check: anti-replay sliding window over 64-bit sequence numbers.
// Throughput: one request per cycle while out_ready does not stall the output.
// The window update is a single compare/shift step.
// Reset (rst_n low, async): window empty, both pipeline stages empty, out_valid low.
// Depends on rwc_pkg and rwc_judge.

module replay_window_check #(
    parameter int WINDOW_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rwc_pkg::SEQ_W-1:0]      sequence_req,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rwc_pkg::VERDICT_W-1:0]  verdict
);

    // Stage 1: input register holding the request's sequence number.
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [rwc_pkg::SEQ_W-1:0]       seq_reg;

    // Stage 2: result register; it parts the window logic from the consumer.
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [rwc_pkg::VERDICT_W-1:0]   verdict_reg;

    logic                            in_fire;
    logic                            s1_move;
    rwc_pkg::judge_req_t             judge_req;
    logic [rwc_pkg::VERDICT_W-1:0]   judge_verdict;

    // The stage-1 request is judged, and the window updated, in the cycle it
    // moves into the result register. The next request therefore always sees
    // the state left by the one before it.
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    // Take a new request whenever stage 1 is empty or draining this cycle,
    // even while a verdict is still waiting downstream.
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    assign judge_req.update = s1_move;
    assign judge_req.seq    = seq_reg;

    rwc_judge #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_judge (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (judge_req),
        .verdict (judge_verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            seq_reg <= sequence_req;
        end
        if (s1_move)
        begin
            verdict_reg <= judge_verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

/* design/rwc_checker.sv */
// rwc_checker: port-level assertions for replay_window_check, attached by bind.
// Depends on rwc_pkg.

module rwc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [rwc_pkg::VERDICT_W-1:0]  verdict
);

    // requests accepted but not yet delivered
    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire && !out_fire)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (out_fire && !in_fire)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two requests in flight");

    a_ready_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg < 2'd2 |-> in_ready)
        else $error("in_ready low with a free stage");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd0 |-> !out_valid)
        else $error("verdict shown with nothing pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict))
        else $error("stalled verdict dropped or changed");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == rwc_pkg::VERDICT_ACCEPTED ||
                       verdict == rwc_pkg::VERDICT_STALE ||
                       verdict == rwc_pkg::VERDICT_DUPLICATE))
        else $error("reserved verdict code");

endmodule

bind replay_window_check rwc_checker u_rwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict)
);
